/* sv/ibs_pkg.sv */
package ibs_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int REL_W      = ANGLE_BITS + 9;
  localparam int CMP_W      = ANGLE_BITS + 11;
  localparam int DEG_W      = 11;
  localparam int SPEED_W    = 16;
  localparam int AR_W       = 10;
  localparam int TGT_W      = 11;
  localparam int MIN_W      = 10;
  localparam int HOLD_W     = 16;
  localparam int CFG_W      = 16;
  localparam int MARGIN_W   = 8;
  localparam int PROD36_W   = 32;
  localparam int PRODM_W    = 26;

  localparam int DIV36_SHIFT = 21;
  localparam logic [15:0] DIV36_RECIP = 16'd58255;
  localparam int MARGIN_SHIFT = 17;
  localparam logic [14:0] MARGIN_RECIP = 15'd31458;

  localparam logic [REL_W-1:0] DEG_FULL = REL_W'(360);

  localparam logic signed [DEG_W-1:0] DEG_5   = DEG_W'(5);
  localparam logic signed [DEG_W-1:0] DEG_15  = DEG_W'(15);
  localparam logic signed [DEG_W-1:0] DEG_35  = DEG_W'(35);
  localparam logic signed [DEG_W-1:0] DEG_145 = DEG_W'(145);
  localparam logic signed [DEG_W-1:0] DEG_165 = DEG_W'(165);
  localparam logic signed [DEG_W-1:0] DEG_175 = DEG_W'(175);
  localparam logic signed [DEG_W-1:0] DEG_180 = DEG_W'(180);
  localparam logic signed [DEG_W-1:0] DEG_185 = DEG_W'(185);
  localparam logic signed [DEG_W-1:0] DEG_195 = DEG_W'(195);
  localparam logic signed [DEG_W-1:0] DEG_215 = DEG_W'(215);
  localparam logic signed [DEG_W-1:0] DEG_325 = DEG_W'(325);
  localparam logic signed [DEG_W-1:0] DEG_345 = DEG_W'(345);
  localparam logic signed [DEG_W-1:0] DEG_355 = DEG_W'(355);
  localparam logic signed [DEG_W-1:0] DEG_360 = DEG_W'(360);

  localparam logic signed [TGT_W-1:0] TARGET_RST = '0;
  localparam logic [MIN_W-1:0]  MIN_SPEED_RST = MIN_W'(150);
  localparam logic [ANGLE_BITS-1:0] ANGLE_BASE_RST = '0;
  localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(1000);

  typedef enum logic [1:0] {
    REG_TARGET     = 2'd0,
    REG_MIN_SPEED  = 2'd1,
    REG_ANGLE_BASE = 2'd2,
    REG_HOLD       = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_STANDBY = 2'd0,
    PH_FIRED   = 2'd1,
    PH_CUT     = 2'd2,
    PH_ENDED   = 2'd3
  } phase_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ARM  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] target;
    logic [MIN_W-1:0]        min_speed;
    logic [ANGLE_BITS-1:0]   angle_base;
    logic [HOLD_W-1:0]       hold;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic             rpm_pos;
    logic             rpm_neg;
    logic             raw_le0;
    logic             raw_ge0;
    logic [AR_W-1:0]  ar;
    logic [REL_W-1:0] rel360;
  } fe_t;

  typedef struct packed {
    op_t                 op;
    logic                arm_ok;
    logic                pos_cond;
    logic                neg_cond;
    logic                speed_ok;
    logic                raw_le0;
    logic                raw_ge0;
    logic [REL_W-1:0]    rel360;
    logic [MARGIN_W-1:0] margin;
    logic                gt15;
    logic                gt195;
    logic                lt165;
    logic                lt345;
    logic                near_pos;
    logic                near_neg;
  } win_t;

  function automatic logic deg_gt(logic [REL_W-1:0] r, logic signed [DEG_W-1:0] d);
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;
    lhs = $signed({2'b00, r});
    rhs = $signed({d, {ANGLE_BITS{1'b0}}});
    return lhs > rhs;
  endfunction

  function automatic logic deg_lt(logic [REL_W-1:0] r, logic signed [DEG_W-1:0] d);
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;
    lhs = $signed({2'b00, r});
    rhs = $signed({d, {ANGLE_BITS{1'b0}}});
    return lhs < rhs;
  endfunction

endpackage

/* sv/ibs_front.sv */
module ibs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ibs_pkg::cfg_t                        cfg_i,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic signed [ibs_pkg::SPEED_W-1:0]   in_motor_speed,
  input  logic [ibs_pkg::ANGLE_BITS-1:0]       in_angle_raw,
  output logic                                 fe_valid_o,
  input  logic                                 fe_ready_i,
  output ibs_pkg::fe_t                         fe_o
);

  logic                                s1_v_r;
  ibs_pkg::op_t                        s1_op_r;
  logic signed [ibs_pkg::SPEED_W-1:0]  s1_raw_r;
  logic [ibs_pkg::ANGLE_BITS-1:0]      s1_ang_r;
  logic                                s2_v_r;
  ibs_pkg::fe_t                        s2_r;
  ibs_pkg::fe_t                        s2_nxt;
  logic                                s1_ld;
  logic                                s2_ld;
  logic [ibs_pkg::SPEED_W-1:0]         mag;
  logic [ibs_pkg::PROD36_W-1:0]        prod;
  logic [ibs_pkg::ANGLE_BITS-1:0]      rel;

  assign s2_ld    = !s2_v_r || fe_ready_i;
  assign s1_ld    = !s1_v_r || s2_ld;
  assign in_ready = s1_ld;

  always_comb begin
    mag  = s1_raw_r[ibs_pkg::SPEED_W-1] ? ibs_pkg::SPEED_W'(-s1_raw_r)
                                         : ibs_pkg::SPEED_W'(s1_raw_r);
    prod = ibs_pkg::PROD36_W'(mag) * ibs_pkg::PROD36_W'(ibs_pkg::DIV36_RECIP);
    rel  = s1_ang_r - cfg_i.angle_base;
    s2_nxt.op      = s1_op_r;
    s2_nxt.ar      = prod[ibs_pkg::DIV36_SHIFT +: ibs_pkg::AR_W];
    s2_nxt.rpm_pos = !s1_raw_r[ibs_pkg::SPEED_W-1] && (s2_nxt.ar != '0);
    s2_nxt.rpm_neg = s1_raw_r[ibs_pkg::SPEED_W-1] && (s2_nxt.ar != '0);
    s2_nxt.raw_le0 = s1_raw_r[ibs_pkg::SPEED_W-1] || (s1_raw_r == '0);
    s2_nxt.raw_ge0 = !s1_raw_r[ibs_pkg::SPEED_W-1];
    s2_nxt.rel360  = ibs_pkg::REL_W'(rel) * ibs_pkg::DEG_FULL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_v_r <= in_valid;
      end
      if (s2_ld) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) begin
      s1_op_r  <= ibs_pkg::op_t'(in_op);
      s1_raw_r <= in_motor_speed;
      s1_ang_r <= in_angle_raw;
    end
    if (s2_ld && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign fe_valid_o = s2_v_r;
  assign fe_o       = s2_r;

endmodule

/* sv/ibs_window.sv */
module ibs_window (
  input  logic          clk,
  input  logic          rst_n,
  input  ibs_pkg::cfg_t cfg_i,
  input  logic          fe_valid_i,
  output logic          fe_ready_o,
  input  ibs_pkg::fe_t  fe_i,
  output logic          win_valid_o,
  input  logic          win_ready_i,
  output ibs_pkg::win_t win_o
);

  logic                          v_r;
  ibs_pkg::win_t                 win_r;
  ibs_pkg::win_t                 win_nxt;
  logic                          ld;
  logic [ibs_pkg::TGT_W-1:0]     tmag;
  logic [ibs_pkg::TGT_W-1:0]     mmax;
  logic [ibs_pkg::PRODM_W-1:0]   prod;
  logic [ibs_pkg::REL_W-1:0]     r;

  assign ld         = !v_r || win_ready_i;
  assign fe_ready_o = ld;

  always_comb begin
    r    = fe_i.rel360;
    tmag = cfg_i.target[ibs_pkg::TGT_W-1] ? ibs_pkg::TGT_W'(-cfg_i.target)
                                           : ibs_pkg::TGT_W'(cfg_i.target);
    mmax = (ibs_pkg::TGT_W'(fe_i.ar) > tmag) ? ibs_pkg::TGT_W'(fe_i.ar) : tmag;
    prod = ibs_pkg::PRODM_W'(mmax) * ibs_pkg::PRODM_W'(ibs_pkg::MARGIN_RECIP);
    win_nxt.op       = fe_i.op;
    win_nxt.arm_ok   = tmag > ibs_pkg::TGT_W'(cfg_i.min_speed);
    win_nxt.pos_cond = fe_i.rpm_pos && !cfg_i.target[ibs_pkg::TGT_W-1] &&
                       (cfg_i.target != '0);
    win_nxt.neg_cond = fe_i.rpm_neg && cfg_i.target[ibs_pkg::TGT_W-1];
    win_nxt.speed_ok = fe_i.ar > cfg_i.min_speed;
    win_nxt.raw_le0  = fe_i.raw_le0;
    win_nxt.raw_ge0  = fe_i.raw_ge0;
    win_nxt.rel360   = r;
    win_nxt.margin   = prod[ibs_pkg::MARGIN_SHIFT +: ibs_pkg::MARGIN_W] +
                       ibs_pkg::MARGIN_W'(1);
    win_nxt.gt15     = ibs_pkg::deg_gt(r, ibs_pkg::DEG_15);
    win_nxt.gt195    = ibs_pkg::deg_gt(r, ibs_pkg::DEG_195);
    win_nxt.lt165    = ibs_pkg::deg_lt(r, ibs_pkg::DEG_165);
    win_nxt.lt345    = ibs_pkg::deg_lt(r, ibs_pkg::DEG_345);
    win_nxt.near_pos = (ibs_pkg::deg_gt(r, ibs_pkg::DEG_145) &&
                        ibs_pkg::deg_lt(r, ibs_pkg::DEG_175)) ||
                       (ibs_pkg::deg_gt(r, ibs_pkg::DEG_325) &&
                        ibs_pkg::deg_lt(r, ibs_pkg::DEG_355));
    win_nxt.near_neg = (ibs_pkg::deg_gt(r, ibs_pkg::DEG_185) &&
                        ibs_pkg::deg_lt(r, ibs_pkg::DEG_215)) ||
                       (ibs_pkg::deg_gt(r, ibs_pkg::DEG_5) &&
                        ibs_pkg::deg_lt(r, ibs_pkg::DEG_35));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= fe_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && fe_valid_i) begin
      win_r <= win_nxt;
    end
  end

  assign win_valid_o = v_r;
  assign win_o       = win_r;

endmodule

/* sv/ibs_core.sv */
module ibs_core (
  input  logic          clk,
  input  logic          rst_n,
  input  ibs_pkg::cfg_t cfg_i,
  input  logic          win_valid_i,
  output logic          win_ready_o,
  input  ibs_pkg::win_t win_i,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_solenoid_on,
  output logic          out_cut_current,
  output logic          out_impact_done,
  output logic          out_arm_rejected,
  output logic [1:0]    out_phase,
  output logic          out_direction,
  output logic          out_active
);

  logic                          running_r, running_nxt;
  ibs_pkg::phase_t               phase_r, phase_nxt;
  logic                          dir_r, dir_nxt;
  logic                          sol_r, sol_nxt;
  logic [ibs_pkg::HOLD_W-1:0]    hold_r, hold_nxt;
  logic                          cut_nxt, done_nxt, rej_nxt;

  logic                          out_v_r;
  logic                          o_sol_r, o_cut_r, o_done_r, o_rej_r, o_dir_r, o_run_r;
  ibs_pkg::phase_t               o_phase_r;

  logic                          ld;
  logic                          adv;
  logic                          is_arm;
  logic                          live;
  logic                          pos_win;
  logic                          neg_win;
  logic                          fire;
  logic                          fire_dir;
  logic                          near;
  logic                          collide;
  logic [ibs_pkg::HOLD_W-1:0]    hold_inc;
  logic signed [ibs_pkg::DEG_W-1:0] m_deg;

  assign ld          = !out_v_r || out_ready;
  assign win_ready_o = ld;
  assign adv         = ld && win_valid_i;
  assign is_arm      = (win_i.op == ibs_pkg::OP_ARM);
  assign live        = running_r && win_i.speed_ok;
  assign m_deg       = $signed(ibs_pkg::DEG_W'(win_i.margin));

  assign pos_win = (win_i.gt15 && ibs_pkg::deg_lt(win_i.rel360, ibs_pkg::DEG_180 - m_deg)) ||
                   (win_i.gt195 && ibs_pkg::deg_lt(win_i.rel360, ibs_pkg::DEG_360 - m_deg));
  assign neg_win = (ibs_pkg::deg_gt(win_i.rel360, ibs_pkg::DEG_180 + m_deg) && win_i.lt345) ||
                   (ibs_pkg::deg_gt(win_i.rel360, m_deg) && win_i.lt165);

  assign fire     = live && (phase_r == ibs_pkg::PH_STANDBY) &&
                    ((win_i.pos_cond && pos_win) || (win_i.neg_cond && neg_win));
  assign fire_dir = fire ? !(win_i.pos_cond && pos_win) : dir_r;
  assign near     = fire_dir ? win_i.near_neg : win_i.near_pos;
  assign collide  = dir_r ? win_i.raw_ge0 : win_i.raw_le0;
  assign hold_inc = (hold_r == '1) ? hold_r : hold_r + ibs_pkg::HOLD_W'(1);

  always_comb begin
    running_nxt = running_r;
    phase_nxt   = phase_r;
    dir_nxt     = dir_r;
    sol_nxt     = sol_r;
    hold_nxt    = hold_r;
    if (is_arm) begin
      if (win_i.arm_ok) begin
        running_nxt = 1'b1;
        phase_nxt   = ibs_pkg::PH_STANDBY;
      end
    end else begin
      hold_nxt = hold_inc;
      if (fire) begin
        dir_nxt   = fire_dir;
        sol_nxt   = 1'b1;
        hold_nxt  = '0;
        phase_nxt = near ? ibs_pkg::PH_CUT : ibs_pkg::PH_FIRED;
      end else if (live) begin
        case (phase_r)
          ibs_pkg::PH_FIRED: begin
            if (near) begin
              phase_nxt = ibs_pkg::PH_CUT;
            end
          end
          ibs_pkg::PH_CUT: begin
            if (collide) begin
              phase_nxt   = ibs_pkg::PH_ENDED;
              sol_nxt     = 1'b0;
              running_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (hold_nxt > cfg_i.hold) begin
        sol_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    rej_nxt  = is_arm && !win_i.arm_ok;
    cut_nxt  = !is_arm && near &&
               (fire || (live && phase_r == ibs_pkg::PH_FIRED));
    done_nxt = !is_arm && !fire && live && (phase_r == ibs_pkg::PH_CUT) && collide;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      phase_r   <= ibs_pkg::PH_STANDBY;
      dir_r     <= 1'b0;
      sol_r     <= 1'b0;
      hold_r    <= '1;
      out_v_r   <= 1'b0;
    end else begin
      if (ld) begin
        out_v_r <= win_valid_i;
      end
      if (adv) begin
        running_r <= running_nxt;
        phase_r   <= phase_nxt;
        dir_r     <= dir_nxt;
        sol_r     <= sol_nxt;
        hold_r    <= hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_sol_r   <= sol_nxt;
      o_cut_r   <= cut_nxt;
      o_done_r  <= done_nxt;
      o_rej_r   <= rej_nxt;
      o_phase_r <= phase_nxt;
      o_dir_r   <= dir_nxt;
      o_run_r   <= running_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_solenoid_on  = o_sol_r;
  assign out_cut_current  = o_cut_r;
  assign out_impact_done  = o_done_r;
  assign out_arm_rejected = o_rej_r;
  assign out_phase        = o_phase_r;
  assign out_direction    = o_dir_r;
  assign out_active       = o_run_r;

  a_run_not_ended: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> phase_r != ibs_pkg::PH_ENDED)
    else $error("running with phase ended");

  a_fire_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sol_r) |-> hold_r == '0)
    else $error("solenoid raised without hold restart");

  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_done_r |-> o_phase_r == ibs_pkg::PH_ENDED && !o_sol_r && !o_run_r)
    else $error("done word with inconsistent state");

  a_cut_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_cut_r |-> o_phase_r == ibs_pkg::PH_CUT && !o_done_r && !o_rej_r)
    else $error("cut word with inconsistent state");

endmodule

/* sv/flywheel_impact_brake_sequencer_unit.sv */
// Flywheel impact brake sequencer. Each input word is an arm request or a control tick
// carrying motor speed and encoder angle; each yields one result word. The block is a
// four-stage pipeline (input register, speed divide and angle scaling, fire-window margin,
// state update into the result register): it takes one word every cycle while the result
// side is not stalled, and the state update in the last stage keeps pace with each word.
// Stalls on the result side back up through the stages. Write configuration only while
// no word is in flight.
module flywheel_impact_brake_sequencer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [ibs_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic signed [ibs_pkg::SPEED_W-1:0]   in_motor_speed,
  input  logic [ibs_pkg::ANGLE_BITS-1:0]       in_angle_raw,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_solenoid_on,
  output logic                                 out_cut_current,
  output logic                                 out_impact_done,
  output logic                                 out_arm_rejected,
  output logic [1:0]                           out_phase,
  output logic                                 out_direction,
  output logic                                 out_active
);

  ibs_pkg::cfg_t cfg_r;
  logic          fe_valid, fe_ready;
  ibs_pkg::fe_t  fe;
  logic          win_valid, win_ready;
  ibs_pkg::win_t win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target     <= ibs_pkg::TARGET_RST;
      cfg_r.min_speed  <= ibs_pkg::MIN_SPEED_RST;
      cfg_r.angle_base <= ibs_pkg::ANGLE_BASE_RST;
      cfg_r.hold       <= ibs_pkg::HOLD_RST;
    end else if (cfg_we) begin
      case (ibs_pkg::cfg_reg_t'(cfg_index))
        ibs_pkg::REG_TARGET:     cfg_r.target     <= $signed(cfg_wdata[ibs_pkg::TGT_W-1:0]);
        ibs_pkg::REG_MIN_SPEED:  cfg_r.min_speed  <= cfg_wdata[ibs_pkg::MIN_W-1:0];
        ibs_pkg::REG_ANGLE_BASE: cfg_r.angle_base <= cfg_wdata[ibs_pkg::ANGLE_BITS-1:0];
        ibs_pkg::REG_HOLD:       cfg_r.hold       <= cfg_wdata[ibs_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ibs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_motor_speed (in_motor_speed),
    .in_angle_raw   (in_angle_raw),
    .fe_valid_o     (fe_valid),
    .fe_ready_i     (fe_ready),
    .fe_o           (fe)
  );

  ibs_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .fe_valid_i  (fe_valid),
    .fe_ready_o  (fe_ready),
    .fe_i        (fe),
    .win_valid_o (win_valid),
    .win_ready_i (win_ready),
    .win_o       (win)
  );

  ibs_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_i            (cfg_r),
    .win_valid_i      (win_valid),
    .win_ready_o      (win_ready),
    .win_i            (win),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_solenoid_on  (out_solenoid_on),
    .out_cut_current  (out_cut_current),
    .out_impact_done  (out_impact_done),
    .out_arm_rejected (out_arm_rejected),
    .out_phase        (out_phase),
    .out_direction    (out_direction),
    .out_active       (out_active)
  );

endmodule
